/* rtl/core/sbfd_pkg.sv */
// ----------------------------------------------------------------------------
// sbfd_pkg
// shared types and constants for the sbus frame decoder
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int unsigned PayloadLen = 22;
  localparam int unsigned ChannelW   = 11;
  localparam int unsigned NumChannels = 16;
  localparam int unsigned PayloadW   = PayloadLen * 8;

  // byte positions within a frame
  localparam logic [4:0] POS_FIRST_DATA = 5'd1;
  localparam logic [4:0] POS_LAST_DATA  = 5'd22;
  localparam logic [4:0] POS_FLAGS      = 5'd23;
  localparam logic [4:0] POS_FOOTER     = 5'd24;

  localparam logic [3:0] LAST_CHANNEL = 4'd15;

  // configuration register indexes and reset values
  localparam logic       REG_HEADER   = 1'b0;
  localparam logic       REG_FOOTER   = 1'b1;
  localparam logic [7:0] HEADER_RESET = 8'h0F;
  localparam logic [7:0] FOOTER_RESET = 8'h00;

  // frame completion, one cycle pulse from the framer
  typedef struct packed {
    logic good;
    logic bad;
  } frame_event_t;

endpackage

/* rtl/core/sbfd_framer.sv */
// ----------------------------------------------------------------------------
// sbfd_framer
// hunts for frame start, collects payload bytes, checks the footer
// ----------------------------------------------------------------------------
module sbfd_framer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  input  logic [7:0]                     byte_data,
  input  logic [7:0]                     header_value,
  input  logic [7:0]                     footer_value,
  output logic                           at_footer,
  output sbfd_pkg::frame_event_t         frame_event,
  output logic [sbfd_pkg::PayloadW-1:0]  payload
);

  logic       in_frame;
  logic [4:0] pos;
  logic [7:0] prev;
  logic [7:0] store [sbfd_pkg::PayloadLen];

  assign at_footer = in_frame && (pos == sbfd_pkg::POS_FOOTER);

  always_comb begin
    frame_event.good = byte_valid && at_footer && (byte_data == footer_value);
    frame_event.bad  = byte_valid && at_footer && (byte_data != footer_value);
  end

  always_comb begin
    for (int i = 0; i < sbfd_pkg::PayloadLen; i++) begin
      payload[8*i +: 8] = store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
      prev     <= '0;
    end else if (byte_valid) begin
      prev <= byte_data;
      if (!in_frame) begin
        if (byte_data == header_value && prev == footer_value) begin
          in_frame <= 1'b1;
          pos      <= sbfd_pkg::POS_FIRST_DATA;
        end
      end else if (pos inside {[sbfd_pkg::POS_FIRST_DATA:sbfd_pkg::POS_LAST_DATA]}) begin
        pos <= pos + 5'd1;
      end else if (pos == sbfd_pkg::POS_FLAGS) begin
        pos <= sbfd_pkg::POS_FOOTER;
      end else begin
        in_frame <= 1'b0;
        pos      <= '0;
      end
    end
  end

  // payload shift line, oldest byte ends at entry 0
  always_ff @(posedge clk) begin
    if (byte_valid && in_frame &&
        pos inside {[sbfd_pkg::POS_FIRST_DATA:sbfd_pkg::POS_LAST_DATA]}) begin
      for (int i = 0; i < sbfd_pkg::PayloadLen - 1; i++) begin
        store[i] <= store[i+1];
      end
      store[sbfd_pkg::PayloadLen-1] <= byte_data;
    end
  end

endmodule

/* rtl/core/sbfd_unpack.sv */
// ----------------------------------------------------------------------------
// sbfd_unpack
// holds a finished frame and sends its channels through the result register
// ----------------------------------------------------------------------------
module sbfd_unpack (
  input  logic                           clk,
  input  logic                           rst,
  input  sbfd_pkg::frame_event_t         frame_event,
  input  logic [sbfd_pkg::PayloadW-1:0]  payload,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     channel_index,
  output logic [sbfd_pkg::ChannelW-1:0]  channel_value,
  output logic                           bad_frame,
  output logic                           last
);

  logic                          bad_mode;
  logic [3:0]                    count;
  logic [sbfd_pkg::PayloadW-1:0] snap;
  logic                          move;

  assign move = busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
        busy      <= !(bad_mode || count == sbfd_pkg::LAST_CHANNEL);
      end else begin
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
        if (!busy && (frame_event.good || frame_event.bad)) begin
          busy <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      channel_index <= bad_mode ? 4'd0 : count;
      channel_value <= bad_mode ? '0 : snap[sbfd_pkg::ChannelW-1:0];
      bad_frame     <= bad_mode;
      last          <= bad_mode || (count == sbfd_pkg::LAST_CHANNEL);
      snap          <= {{sbfd_pkg::ChannelW{1'b0}},
                        snap[sbfd_pkg::PayloadW-1:sbfd_pkg::ChannelW]};
      count         <= count + 4'd1;
    end else if (!busy) begin
      snap     <= payload;
      count    <= '0;
      bad_mode <= frame_event.bad;
    end
  end

  a_load_when_free : assert property (@(posedge clk) disable iff (rst)
    (frame_event.good || frame_event.bad) |-> !busy)
    else $error("frame completed while previous frame still unpacking");

  a_event_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(frame_event.good && frame_event.bad))
    else $error("frame both good and bad");

  a_good_last_index : assert property (@(posedge clk) disable iff (rst)
    (out_valid && last && !bad_frame) |-> channel_index == sbfd_pkg::LAST_CHANNEL)
    else $error("good frame run ended early");

  a_bad_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_frame) |-> (last && channel_value == '0 && channel_index == 4'd0))
    else $error("malformed bad frame result");

endmodule

/* rtl/core/sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// byte-stream framer for 25-byte remote-control frames
// ----------------------------------------------------------------------------
// Takes one received byte per request and frames header, 22 payload bytes,
// flags and footer. A header only opens a frame when the byte before it was
// the footer value. A frame whose footer matches produces a run of 16 results,
// channels 0..15 with 11-bit values unpacked LSB-first, last set on channel
// 15; a mismatched footer produces one result with bad_frame and last set.
// Bytes are taken one per cycle. A byte passes through the input register into
// the framer; a finished frame is copied into a snapshot and its results leave
// one per cycle through the result register unless out_stall holds them, so
// the framer keeps taking bytes while a run drains. Only the footer byte of
// the next frame waits, and only while the previous run is still in the snapshot.
// The user writes header and footer values on the cfg port (index 0 header,
// index 1 footer) only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [7:0]                     cfg_data,
  // byte requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // channel results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     channel_index,
  output logic [sbfd_pkg::ChannelW-1:0]  channel_value,
  output logic                           bad_frame,
  output logic                           last
);

  logic [7:0] header_value;
  logic [7:0] footer_value;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  logic                          at_footer;
  logic                          busy;
  sbfd_pkg::frame_event_t        frame_event;
  logic [sbfd_pkg::PayloadW-1:0] payload;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= sbfd_pkg::HEADER_RESET;
      footer_value <= sbfd_pkg::FOOTER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sbfd_pkg::REG_HEADER: header_value <= cfg_data;
        sbfd_pkg::REG_FOOTER: footer_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // the footer byte holds in the input register until the snapshot is free
  assign advance  = in_full && (!at_footer || !busy);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  sbfd_framer u_framer (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (advance),
    .byte_data    (in_byte),
    .header_value (header_value),
    .footer_value (footer_value),
    .at_footer    (at_footer),
    .frame_event  (frame_event),
    .payload      (payload)
  );

  sbfd_unpack u_unpack (
    .clk           (clk),
    .rst           (rst),
    .frame_event   (frame_event),
    .payload       (payload),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .bad_frame     (bad_frame),
    .last          (last)
  );

  a_stall_only_at_footer : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && at_footer && busy))
    else $error("input stalled without a pending footer");

  a_no_event_without_byte : assert property (@(posedge clk) disable iff (rst)
    !advance |-> !(frame_event.good || frame_event.bad))
    else $error("frame event without a byte");

  a_empty_no_stall : assert property (@(posedge clk) disable iff (rst)
    !in_full |-> !in_stall)
    else $error("stall with empty input register");

endmodule

/* tb/tb_sbus_frame_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_decoder
// self-checking bench for the sbus frame decoder
// ----------------------------------------------------------------------------
// Byte requests are driven in random bursts while the result side stalls on
// its own pattern. Every accepted byte runs through a frame predictor that
// queues the channel results it should produce; every accepted result is
// checked field by field against the oldest one. Traffic is mostly whole
// frames with random payload, mixed with noise, bad footers and cut-off
// frames, under several header and footer settings including the extremes.
// ----------------------------------------------------------------------------

typedef struct {
  logic [3:0]                    index;
  logic [sbfd_pkg::ChannelW-1:0] value;
  logic                          bad;
  logic                          last;
} channel_result_t;

class frame_scoreboard;
  logic [7:0] header_value;
  logic [7:0] footer_value;
  logic [7:0] payload [sbfd_pkg::PayloadLen];
  logic [4:0] position;
  bit         in_frame;
  logic [7:0] prev_byte;
  channel_result_t pending_channels[$];
  int errors;
  int checked;
  int good_frames;
  int bad_frames;

  function void clear();
    header_value = sbfd_pkg::HEADER_RESET;
    footer_value = sbfd_pkg::FOOTER_RESET;
    foreach (payload[i]) payload[i] = 8'h00;
    position  = 5'd0;
    in_frame  = 1'b0;
    prev_byte = 8'h00;
    pending_channels.delete();
    errors = 0;
    checked = 0;
    good_frames = 0;
    bad_frames = 0;
  endfunction

  function void set_reg(logic idx, logic [7:0] v);
    if (idx == sbfd_pkg::REG_HEADER) header_value = v;
    else footer_value = v;
  endfunction

  function void note_byte(logic [7:0] b);
    logic [7:0] seen;
    logic [sbfd_pkg::PayloadW-1:0] bits;
    channel_result_t r;
    seen = prev_byte;
    prev_byte = b;
    if (!in_frame) begin
      if (b == header_value && seen == footer_value) begin
        in_frame = 1'b1;
        position = sbfd_pkg::POS_FIRST_DATA;
      end
      return;
    end
    if (position >= sbfd_pkg::POS_FIRST_DATA && position <= sbfd_pkg::POS_LAST_DATA) begin
      payload[position - 1] = b;
      position = position + 5'd1;
    end else if (position == sbfd_pkg::POS_FLAGS) begin
      position = sbfd_pkg::POS_FOOTER;
    end else begin
      if (position == sbfd_pkg::POS_FOOTER) begin
        if (b == footer_value) begin
          for (int i = 0; i < sbfd_pkg::PayloadLen; i++) bits[8*i +: 8] = payload[i];
          for (int k = 0; k < sbfd_pkg::NumChannels; k++) begin
            r.index = k[3:0];
            r.value = bits[sbfd_pkg::ChannelW*k +: sbfd_pkg::ChannelW];
            r.bad   = 1'b0;
            r.last  = (r.index == sbfd_pkg::LAST_CHANNEL);
            pending_channels.push_back(r);
          end
          good_frames++;
        end else begin
          r.index = 4'd0;
          r.value = '0;
          r.bad   = 1'b1;
          r.last  = 1'b1;
          pending_channels.push_back(r);
          bad_frames++;
        end
      end
      in_frame = 1'b0;
      position = 5'd0;
    end
  endfunction

  function void fail_field(string name, int exp, int act);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
  endfunction

  function void check_result(logic [3:0] idx, logic [sbfd_pkg::ChannelW-1:0] val,
                             logic bad, logic lst);
    channel_result_t e;
    checked++;
    if (pending_channels.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: unexpected result, expected none actual ch %0d val %0h bad %0b",
                 $time, idx, val, bad);
      return;
    end
    e = pending_channels.pop_front();
    if (idx !== e.index) fail_field("channel_index", e.index, idx);
    if (val !== e.value) fail_field("channel_value", e.value, val);
    if (bad !== e.bad) fail_field("bad_frame", e.bad, bad);
    if (lst !== e.last) fail_field("last", e.last, lst);
  endfunction

  function void flush_check();
    if (pending_channels.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived, expected ch %0d first",
               $time, pending_channels.size(), pending_channels[0].index);
    end
  endfunction
endclass

module tb_sbus_frame_decoder;

  localparam int IdleLimit    = 2000;  // cycles with no request moving on either side
  localparam int SettleCycles = 12;    // pipeline slack before a register write
  localparam int FILL_RANDOM  = 0;
  localparam int FILL_SPLIT   = 1;     // low half zeros, high half ones

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = sbfd_pkg::REG_HEADER;
  logic [7:0] cfg_data = 8'h00;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] channel_index;
  logic [sbfd_pkg::ChannelW-1:0] channel_value;
  logic bad_frame;
  logic last;

  frame_scoreboard sb;
  int bytes_sent = 0;
  int burst_left = 0;
  int stall_cycle = 0;
  int idle_cycles = 0;

  sbus_frame_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .bad_frame     (bad_frame),
    .last          (last)
  );

  always #2 clk = ~clk;

  // sample both channels at the rising edge, results before bytes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result(channel_index, channel_value, bad_frame, last);
      if (in_valid && !in_stall) begin
        sb.note_byte(rx_byte);
        bytes_sent++;
      end
    end
  end

  // receiver stall pattern, four modes in turn
  always @(negedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 100) % 4)
      0: out_stall <= 1'b0;                              // free running
      1: out_stall <= ($urandom_range(0, 3) == 0);       // light stalls
      2: out_stall <= ($urandom_range(0, 3) != 0);       // heavy stalls
      default: out_stall <= ((stall_cycle % 24) < 14);  // long stall stretches
    endcase
  end

  // watchdog on cycles where nothing moves
  initial begin
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t ns: no progress for %0d cycles", $time, IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // one byte request; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // register write while idle, keeps the predictor in step
  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, let every expected result drain, then let the pipe settle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_channels.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // payload byte biased toward the framing values
  function automatic logic [7:0] data_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return sb.header_value;
    if (pick == 1) return sb.footer_value;
    return 8'($urandom_range(0, 255));
  endfunction

  // a whole frame, preceded by whatever is needed to get back to hunting
  task automatic send_frame(input int fill, input bit good);
    logic [7:0] fb;
    while (sb.in_frame) push_byte(8'($urandom_range(0, 255)));  // close an open frame
    if (sb.prev_byte != sb.footer_value) push_byte(sb.footer_value);
    push_byte(sb.header_value);
    for (int i = 0; i < sbfd_pkg::PayloadLen; i++) begin
      if (fill == FILL_SPLIT) push_byte((i < sbfd_pkg::PayloadLen / 2) ? 8'h00 : 8'hFF);
      else push_byte(data_byte());
    end
    // flags byte, ignored; header value here is plain data
    push_byte((fill == FILL_SPLIT) ? sb.header_value : data_byte());
    fb = good ? sb.footer_value : (sb.footer_value ^ 8'($urandom_range(1, 255)));
    push_byte(fb);
  endtask

  // mostly good frames, plus noise, bad footers and cut-off frames
  task automatic run_traffic(input int min_bytes, input int min_frames);
    int start_bytes;
    int start_frames;
    start_bytes  = bytes_sent;
    start_frames = sb.good_frames + sb.bad_frames;
    while (bytes_sent - start_bytes < min_bytes ||
           sb.good_frames + sb.bad_frames - start_frames < min_frames) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 6)) push_byte(data_byte());
        1: begin
          // frame opened and cut short, the next frame absorbs the rest
          if (!sb.in_frame && sb.prev_byte != sb.footer_value) push_byte(sb.footer_value);
          push_byte(sb.header_value);
          repeat ($urandom_range(1, 12)) push_byte(data_byte());
        end
        2: send_frame(FILL_RANDOM, 1'b0);
        default: send_frame(FILL_RANDOM, 1'b1);
      endcase
    end
  endtask

  initial begin
    logic [7:0] v;
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // leading header right after reset, channel values at both extremes
    send_frame(FILL_SPLIT, 1'b1);
    // header with no footer just before it is ignored
    push_byte(8'h55);
    push_byte(sb.header_value);
    // footer mismatch
    send_frame(FILL_RANDOM, 1'b0);
    settle();

    write_reg(sbfd_pkg::REG_HEADER, 8'hFF);
    write_reg(sbfd_pkg::REG_FOOTER, 8'h00);
    run_traffic(0, 1);
    settle();

    write_reg(sbfd_pkg::REG_HEADER, 8'h00);
    write_reg(sbfd_pkg::REG_FOOTER, 8'hFF);
    run_traffic(0, 1);
    settle();

    // header and footer equal
    v = 8'($urandom_range(0, 255));
    write_reg(sbfd_pkg::REG_HEADER, v);
    write_reg(sbfd_pkg::REG_FOOTER, v);
    run_traffic(0, 1);
    settle();

    sb.flush_check();
    $display("run covered %0d bytes, %0d good and %0d bad frames, %0d results checked",
             bytes_sent, sb.good_frames, sb.bad_frames, sb.checked);
    $display("four header/footer settings, %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sbus_frame_decoder.f */
rtl/core/sbfd_pkg.sv
rtl/core/sbfd_framer.sv
rtl/core/sbfd_unpack.sv
rtl/core/sbus_frame_decoder.sv
tb/tb_sbus_frame_decoder.sv
